// ===== rtl/lsf_pkg.sv =====
// Shared widths, register indexes and saturation limits for the largest square finder.
package lsf_pkg;

    localparam int SIZE_W   = 11;
    localparam int CORNER_W = 10;
    localparam int CFG_W    = 11;
    localparam int DIM_W    = 17;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [CORNER_W-1:0] t_corner;
    typedef logic [CFG_W-1:0]    t_cfg;
    typedef logic [DIM_W-1:0]    t_dim;

    localparam t_size SIZE_SAT = 11'd2047;
    localparam t_cfg  DIM_RESET = 11'd1024;

    // Register indexes, taken from paddr[2].
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

endpackage

// ===== rtl/lsf_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
module lsf_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/largest_square_finder_unit.sv =====
// Streaming maximal free square search over a raster-ordered binary grid.
// Throughput: one cell transaction per clock cycle for any grid shape, unless a finished
// result finds the output busy. Stage 1 ends each grid by loading the output register.
// The rate is set by the line buffer RAM: one read and one write of it per cell.
// Reset (synchronous, active low) clears the counters, sizes, best entry and the result
// valid flag, and sets both grid dimensions to 1024; the line buffer is not cleared.
module largest_square_finder_unit #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lsf_pkg::APB_AW-1:0] paddr,
    input  logic [lsf_pkg::APB_DW-1:0] pwdata,
    output logic [lsf_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    // Cell input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_cell_free,
    // Result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lsf_pkg::SIZE_W-1:0]   o_square_size,
    output logic [lsf_pkg::CORNER_W-1:0] o_corner_row,
    output logic [lsf_pkg::CORNER_W-1:0] o_corner_col
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam lsf_pkg::t_dim MAX_C = lsf_pkg::DIM_W'(MAX_COLS);
    localparam lsf_pkg::t_dim MAX_R = lsf_pkg::DIM_W'(MAX_ROWS);

    // ------------------------------------------------------------------
    // Configuration registers. The user must make writes only while the block
    // is idle; the block does not enforce it and has no datapath interlock.
    // ------------------------------------------------------------------
    lsf_pkg::t_cfg r_grid_rows;
    lsf_pkg::t_cfg r_grid_cols;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= lsf_pkg::DIM_RESET;
            r_grid_cols <= lsf_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                lsf_pkg::REG_GRID_ROWS: r_grid_rows <= pwdata[lsf_pkg::CFG_W-1:0];
                lsf_pkg::REG_GRID_COLS: r_grid_cols <= pwdata[lsf_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lsf_pkg::REG_GRID_ROWS: prdata = lsf_pkg::APB_DW'(r_grid_rows);
            lsf_pkg::REG_GRID_COLS: prdata = lsf_pkg::APB_DW'(r_grid_cols);
            default:                prdata = '0;
        endcase
    end

    // The dimensions in use are saturated into 1..MAX; a zero counts as one.
    lsf_pkg::t_cfg cols_eff;
    lsf_pkg::t_cfg rows_eff;

    always_comb begin
        if (r_grid_cols == '0) begin
            cols_eff = lsf_pkg::CFG_W'(1);
        end else if (lsf_pkg::DIM_W'(r_grid_cols) > MAX_C) begin
            cols_eff = MAX_C[lsf_pkg::CFG_W-1:0];
        end else begin
            cols_eff = r_grid_cols;
        end
        if (r_grid_rows == '0) begin
            rows_eff = lsf_pkg::CFG_W'(1);
        end else if (lsf_pkg::DIM_W'(r_grid_rows) > MAX_R) begin
            rows_eff = MAX_R[lsf_pkg::CFG_W-1:0];
        end else begin
            rows_eff = r_grid_rows;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: the cell transaction is accepted, the raster position is
    // attached to it and the line buffer entry for its column is read.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          col_last;
    logic          row_last;
    logic          accept;
    logic          stall;

    assign col_last = (lsf_pkg::DIM_W'(r_col) + lsf_pkg::DIM_W'(1))
                      >= lsf_pkg::DIM_W'(cols_eff);
    assign row_last = (lsf_pkg::DIM_W'(r_row) + lsf_pkg::DIM_W'(1))
                      >= lsf_pkg::DIM_W'(rows_eff);

    // Stage 1 can only be held up by a finished result that finds the
    // output register still occupied and not being taken this cycle.
    logic          r_s1_valid;
    logic          r_s1_last_grid;

    assign stall      = r_s1_valid & r_s1_last_grid & o_out_valid & ~i_out_ready;
    assign o_in_ready = ~stall;
    assign accept     = i_in_valid & ~stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the square size is formed from the left, upper and diagonal
    // sizes, written back into the line buffer and compared with the best.
    // ------------------------------------------------------------------
    logic                r_s1_cell;
    logic                r_s1_edge;
    logic                r_s1_last_col;
    logic [CW-1:0]       r_s1_col;
    logic [RW-1:0]       r_s1_row;
    logic                r_s1_fwd;
    lsf_pkg::t_size      r_fwd_val;
    logic                s1_adv;
    lsf_pkg::t_size      ram_rd_data;
    lsf_pkg::t_size      up_size;
    lsf_pkg::t_size      min_size;
    logic [lsf_pkg::SIZE_W:0] inc_size;
    lsf_pkg::t_size      size;

    lsf_pkg::t_size      r_left;
    lsf_pkg::t_size      r_diag;
    lsf_pkg::t_size      r_best_size;
    logic [RW-1:0]       r_best_row;
    logic [CW-1:0]       r_best_col;
    lsf_pkg::t_size      n_best_size;
    logic [RW-1:0]       n_best_row;
    logic [CW-1:0]       n_best_col;

    assign s1_adv = r_s1_valid & ~stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (!stall) begin
            r_s1_valid <= accept;
            // With a single column the next row reads the entry that stage 1
            // writes in the same cycle, so its new value is forwarded.
            r_s1_fwd   <= accept & r_s1_valid & (r_s1_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cell      <= i_cell_free;
            r_s1_edge      <= (r_row == '0) || (r_col == '0);
            r_s1_last_col  <= col_last;
            r_s1_last_grid <= col_last & row_last;
            r_s1_col       <= r_col;
            r_s1_row       <= r_row;
            r_fwd_val      <= size;
        end
    end

    lsf_ram #(
        .WIDTH (lsf_pkg::SIZE_W),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (size),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        up_size  = r_s1_fwd ? r_fwd_val : ram_rd_data;
        min_size = r_left;
        if (up_size < min_size) begin
            min_size = up_size;
        end
        if (r_diag < min_size) begin
            min_size = r_diag;
        end
        inc_size = {1'b0, min_size} + (lsf_pkg::SIZE_W+1)'(1);

        if (r_s1_edge) begin
            size = lsf_pkg::SIZE_W'(r_s1_cell);
        end else if (r_s1_cell) begin
            size = inc_size[lsf_pkg::SIZE_W] ? lsf_pkg::SIZE_SAT
                                             : inc_size[lsf_pkg::SIZE_W-1:0];
        end else begin
            size = '0;
        end

        // A strictly larger size is needed, so ties keep the first corner.
        if (size > r_best_size) begin
            n_best_size = size;
            n_best_row  = r_s1_row;
            n_best_col  = r_s1_col;
        end else begin
            n_best_size = r_best_size;
            n_best_row  = r_best_row;
            n_best_col  = r_best_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (s1_adv) begin
            r_left <= r_s1_last_col ? '0 : size;
            r_diag <= r_s1_last_col ? '0 : up_size;
            if (r_s1_last_grid) begin
                r_best_size <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else begin
                r_best_size <= n_best_size;
                r_best_row  <= n_best_row;
                r_best_col  <= n_best_col;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished result while the next grid's
    // cells continue to flow through the stages above.
    // ------------------------------------------------------------------
    logic                 r_out_valid;
    lsf_pkg::t_size       r_out_size;
    lsf_pkg::t_corner     r_out_row;
    lsf_pkg::t_corner     r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last_grid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last_grid) begin
            r_out_size <= n_best_size;
            r_out_row  <= lsf_pkg::CORNER_W'(n_best_row);
            r_out_col  <= lsf_pkg::CORNER_W'(n_best_col);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_square_size = r_out_size;
    assign o_corner_row  = r_out_row;
    assign o_corner_col  = r_out_col;

endmodule

// ===== rtl/lsf_checker.sv =====
// Port-level checker for the largest square finder, bound to the top level.
module lsf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         pready,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [lsf_pkg::SIZE_W-1:0]   o_square_size,
    input logic [lsf_pkg::CORNER_W-1:0] o_corner_row,
    input logic [lsf_pkg::CORNER_W-1:0] o_corner_col
);

    // A pending result is held unchanged until its transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_square_size) && $stable(o_corner_row)
             && $stable(o_corner_col)))
        else $error("result changed or dropped while stalled");

    // The cell input is only held off by a result that cannot leave.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input held off without a stalled result");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A grid without a free cell reports the origin as its corner.
    a_empty_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_square_size == '0)) |->
            ((o_corner_row == '0) && (o_corner_col == '0)))
        else $error("empty grid with a non-zero corner");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind largest_square_finder_unit lsf_checker u_lsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_square_size (o_square_size),
    .o_corner_row  (o_corner_row),
    .o_corner_col  (o_corner_col)
);
